[hw/rtl/nlfsr_pkg.sv]
// Package: register geometry, tap positions and the eight-step keystream function.
package nlfsr_pkg;

    localparam int unsigned UNIT_BITS      = 8;
    localparam int unsigned REGISTER_UNITS = 12;
    localparam int unsigned STATE_W        = UNIT_BITS * REGISTER_UNITS;
    localparam int unsigned KEY_HIGH_W     = 32;
    localparam int unsigned KEY_LOW_W      = STATE_W - KEY_HIGH_W;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned CFG_DATA_W     = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd1;

    // Tap p is bit p mod 8 of byte p/8, byte 0 sitting at the top of the vector.
    localparam int unsigned T3  = (REGISTER_UNITS - 1 - 3 / UNIT_BITS) * UNIT_BITS + 3 % UNIT_BITS;
    localparam int unsigned T25 = (REGISTER_UNITS - 1 - 25 / UNIT_BITS) * UNIT_BITS + 25 % UNIT_BITS;
    localparam int unsigned T10 = (REGISTER_UNITS - 1 - 10 / UNIT_BITS) * UNIT_BITS + 10 % UNIT_BITS;
    localparam int unsigned T90 = (REGISTER_UNITS - 1 - 90 / UNIT_BITS) * UNIT_BITS + 90 % UNIT_BITS;
    localparam int unsigned T30 = (REGISTER_UNITS - 1 - 30 / UNIT_BITS) * UNIT_BITS + 30 % UNIT_BITS;
    localparam int unsigned T47 = (REGISTER_UNITS - 1 - 47 / UNIT_BITS) * UNIT_BITS + 47 % UNIT_BITS;
    localparam int unsigned T81 = (REGISTER_UNITS - 1 - 81 / UNIT_BITS) * UNIT_BITS + 81 % UNIT_BITS;
    localparam int unsigned T67 = (REGISTER_UNITS - 1 - 67 / UNIT_BITS) * UNIT_BITS + 67 % UNIT_BITS;
    localparam int unsigned T52 = (REGISTER_UNITS - 1 - 52 / UNIT_BITS) * UNIT_BITS + 52 % UNIT_BITS;
    localparam int unsigned T26 = (REGISTER_UNITS - 1 - 26 / UNIT_BITS) * UNIT_BITS + 26 % UNIT_BITS;
    localparam int unsigned T95 = (REGISTER_UNITS - 1 - 95 / UNIT_BITS) * UNIT_BITS + 95 % UNIT_BITS;
    localparam int unsigned T39 = (REGISTER_UNITS - 1 - 39 / UNIT_BITS) * UNIT_BITS + 39 % UNIT_BITS;
    localparam int unsigned T76 = (REGISTER_UNITS - 1 - 76 / UNIT_BITS) * UNIT_BITS + 76 % UNIT_BITS;
    localparam int unsigned T82 = (REGISTER_UNITS - 1 - 82 / UNIT_BITS) * UNIT_BITS + 82 % UNIT_BITS;

    typedef logic [STATE_W-1:0]   t_state;
    typedef logic [UNIT_BITS-1:0] t_byte;

    typedef struct packed {
        t_state state;
        t_byte  keystream;
    } t_step;

    // Eight bit steps: take the combiner bit MSB first, then shift in the feedback bit.
    function automatic t_step byte_step(input t_state s_in);
        t_step  res;
        t_state s;
        logic   c;
        logic   f;
        s = s_in;
        res.keystream = '0;
        for (int i = 0; i < int'(UNIT_BITS); i++) begin
            c = s[T67] ^ s[T52] ^ (s[T26] & s[T95]) ^ (s[T39] & s[T76] & s[T82]);
            f = s[T3] ^ s[T25] ^ (s[T10] & s[T90]) ^ (s[T30] & s[T47] & s[T81]);
            res.keystream = {res.keystream[UNIT_BITS-2:0], c};
            s = {s[STATE_W-2:0], f};
        end
        res.state = s;
        return res;
    endfunction

endpackage

[hw/rtl/nlfsr_stream_cipher_unit.sv]
// Top level: byte-wide NLFSR stream cipher with key registers and a single output register.
//
// Each accepted byte is XORed with eight keystream bits (first bit in the MSB) taken from a
// 96-bit nonlinear feedback shift register. One byte is accepted every clock cycle while the
// result side keeps up, and its result appears in the output register on the next cycle. While
// a result waits with m_axis_tready low, the input is stalled. All eight register steps are
// evaluated combinationally by unrolled XOR/AND logic in front of the state register. A set
// tuser bit reloads the register from key_high (bytes 0..3) and key_low (bytes 4..11) before
// the byte is processed. Key writes take effect at the next restart. Encryption and
// decryption are the same operation.
module nlfsr_stream_cipher_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [nlfsr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [nlfsr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tuser,  // [0] restart
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata   // [7:0] out_byte
);

    logic [nlfsr_pkg::KEY_HIGH_W-1:0] r_key_high;
    logic [nlfsr_pkg::KEY_LOW_W-1:0]  r_key_low;
    nlfsr_pkg::t_state                r_lfsr;
    nlfsr_pkg::t_byte                 r_out;
    logic                             r_out_valid;

    nlfsr_pkg::t_state n_lfsr_start;
    nlfsr_pkg::t_step  n_step;
    logic              s_fire;
    logic              m_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Reload from the keys first when restart is set.
    assign n_lfsr_start = s_axis_tuser ? {r_key_high, r_key_low} : r_lfsr;
    assign n_step       = nlfsr_pkg::byte_step(n_lfsr_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nlfsr_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data[nlfsr_pkg::KEY_HIGH_W-1:0];
                nlfsr_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data[nlfsr_pkg::KEY_LOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_lfsr      <= n_step.state;
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= s_axis_tdata ^ n_step.keystream;
        end
    end

    // A transaction in always leaves a result waiting next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // Never take a byte while the pending result is stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted over a stalled result");

    // Hold the register when no byte is taken.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_fire |=> $stable(r_lfsr))
        else $error("register advanced without a transaction");

    // Drop the result once delivered with nothing new behind it.
    a_result_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && !s_fire) |=> !m_axis_tvalid)
        else $error("result repeated after delivery");

endmodule

[sim/tb_top.sv]
// Testbench: stream cipher unit against a bit-level keystream predictor, with random back-pressure.
module tb_top;

    typedef logic [nlfsr_pkg::CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_RSVD2 = 2'd2;
    localparam t_cfg_index CFG_RSVD3 = 2'd3;

    localparam int PHASE_ITEMS    = 360;
    localparam int REKEY_EVERY    = 120;
    localparam int SETTLE_CYCLES  = 3;
    localparam int LONG_HOLD      = 90;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIRECTED_ROWS  = 25;

    typedef enum logic {ROW_KEY, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        t_cfg_index                         idx;
        logic [nlfsr_pkg::CFG_DATA_W-1:0]   val;
        nlfsr_pkg::t_byte                   data;
        logic                               restart;
        logic                               typed;
        nlfsr_pkg::t_byte                   typed_out;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    t_cfg_index                       i_cfg_index = '0;
    logic [nlfsr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [7:0]                       m_axis_tdata;

    // predictor state
    nlfsr_pkg::t_state                cipher_reg = '0;
    logic [nlfsr_pkg::KEY_HIGH_W-1:0] key_hi_m = '0;
    logic [nlfsr_pkg::KEY_LOW_W-1:0]  key_lo_m = '0;

    nlfsr_pkg::t_byte       pending_cipher [$];
    int                     mismatches = 0;
    int                     results_seen = 0;
    int                     src_idle_pct = 0;
    int                     sink_idle_pct = 0;
    bit                     cfg_open = 1'b0;
    t_row                   directed_plan [DIRECTED_ROWS];

    nlfsr_stream_cipher_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Tap p: bit p mod 8 of byte p/8, byte 0 at the top of the vector.
    function automatic logic reg_tap(input int unsigned p);
        return cipher_reg[(nlfsr_pkg::REGISTER_UNITS - 1 - p / nlfsr_pkg::UNIT_BITS)
                          * nlfsr_pkg::UNIT_BITS + p % nlfsr_pkg::UNIT_BITS];
    endfunction

    function automatic nlfsr_pkg::t_byte encipher(input nlfsr_pkg::t_byte d, input logic reload);
        nlfsr_pkg::t_byte ks;
        logic             comb;
        logic             fb;
        if (reload)
            cipher_reg = {key_hi_m, key_lo_m};
        ks = '0;
        for (int i = 0; i < int'(nlfsr_pkg::UNIT_BITS); i++) begin
            comb = reg_tap(67) ^ reg_tap(52) ^ (reg_tap(26) & reg_tap(95))
                 ^ (reg_tap(39) & reg_tap(76) & reg_tap(82));
            fb   = reg_tap(3) ^ reg_tap(25) ^ (reg_tap(10) & reg_tap(90))
                 ^ (reg_tap(30) & reg_tap(47) & reg_tap(81));
            ks = {ks[nlfsr_pkg::UNIT_BITS-2:0], comb};
            cipher_reg = {cipher_reg[nlfsr_pkg::STATE_W-2:0], fb};
        end
        return d ^ ks;
    endfunction

    task automatic report_mismatch(input string what, input nlfsr_pkg::t_byte got,
                                   input nlfsr_pkg::t_byte want);
        mismatches++;
        $display("MISMATCH %s: got %02h expected %02h", what, got, want);
    endtask

    // Leave the config channel high between back-to-back writes; close it before anything else.
    task automatic cfg_write(input t_cfg_index idx,
                             input logic [nlfsr_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_open = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == nlfsr_pkg::CFG_KEY_HIGH)
            key_hi_m = val[nlfsr_pkg::KEY_HIGH_W-1:0];
        else if (idx == nlfsr_pkg::CFG_KEY_LOW)
            key_lo_m = val[nlfsr_pkg::KEY_LOW_W-1:0];
    endtask

    task automatic send_item(input nlfsr_pkg::t_byte d, input logic reload,
                             input logic typed = 1'b0,
                             input nlfsr_pkg::t_byte typed_out = '0);
        nlfsr_pkg::t_byte want;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= reload;
        do @(posedge i_clk); while (!s_axis_tready);
        want = encipher(d, reload);
        pending_cipher.push_back(typed ? typed_out : want);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while (pending_cipher.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic rekey_random();
        wait_idle();
        cfg_write(nlfsr_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        cfg_write(nlfsr_pkg::CFG_KEY_LOW, {$urandom, $urandom});
        cfg_write(t_cfg_index'($urandom_range(3)), {$urandom, $urandom});
    endtask

    // result side: check, count, and drive tready with random stalls and two long hold-offs
    initial begin
        int               hold_left;
        nlfsr_pkg::t_byte want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_cipher.size() == 0) begin
                    report_mismatch("unexpected transaction", m_axis_tdata, '0);
                end else begin
                    want = pending_cipher.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("out_byte", m_axis_tdata, want);
                end
                results_seen++;
                if (results_seen == 200 || results_seen == 700)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("nlfsr_stream_cipher_unit verification failed");
        $finish;
    end

    initial begin
        directed_plan = '{
            // zero keys and zero register: keystream is all zero
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h00, 1'b0, 1'b1, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hFF, 1'b0, 1'b1, 8'hFF},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hA5, 1'b1, 1'b1, 8'hA5},
            // unmapped indexes must leave the keys at zero
            '{ROW_KEY,  CFG_RSVD2, '1, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_KEY,  CFG_RSVD3, '1, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h5A, 1'b1, 1'b1, 8'h5A},
            // key writes alone do not touch the register
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_HIGH, '1, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_LOW,  '1, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h3C, 1'b0, 1'b1, 8'h3C},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h00, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h80, 1'b1, 1'b0, 8'h00},
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_HIGH, 64'h8000_0000, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_LOW,  64'h1, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h01, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h7F, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h80, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hFE, 1'b0, 1'b0, 8'h00},
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_HIGH, 64'h5A5A_0F0F_0123_4567,
              8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_KEY,  nlfsr_pkg::CFG_KEY_LOW,  64'h89AB_CDEF_0F1E_2D3C,
              8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h55, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hAA, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, nlfsr_pkg::CFG_KEY_HIGH, 64'd0, 8'h00, 1'b1, 1'b0, 8'h00}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == ROW_KEY) begin
                if (!cfg_open)
                    wait_idle();
                cfg_write(directed_plan[k].idx, directed_plan[k].val);
            end else begin
                send_item(directed_plan[k].data, directed_plan[k].restart,
                          directed_plan[k].typed, directed_plan[k].typed_out);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    src_idle_pct  = 38;
                    sink_idle_pct = 63;
                    cfg_write(nlfsr_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
                    cfg_write(nlfsr_pkg::CFG_KEY_LOW, {$urandom, $urandom});
                end
                1: begin
                    src_idle_pct  = 63;
                    sink_idle_pct = 38;
                    cfg_write(nlfsr_pkg::CFG_KEY_HIGH, '0);
                    cfg_write(nlfsr_pkg::CFG_KEY_LOW, '1);
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    cfg_write(nlfsr_pkg::CFG_KEY_HIGH, '1);
                    cfg_write(nlfsr_pkg::CFG_KEY_LOW, '0);
                end
            endcase
            send_item(nlfsr_pkg::t_byte'($urandom_range(255)), 1'b1);
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                if (n % REKEY_EVERY == 0) begin
                    rekey_random();
                    send_item(nlfsr_pkg::t_byte'($urandom_range(255)), 1'b1);
                end else begin
                    // mostly long keystream runs, with the odd restart burst
                    send_item(nlfsr_pkg::t_byte'($urandom_range(255)),
                              $urandom_range(11) == 0);
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("nlfsr_stream_cipher_unit verification clean");
        else
            $display("nlfsr_stream_cipher_unit verification failed");
        $finish;
    end

endmodule
